FILE: hw/rtl/mouse_event_frame_latcher_core_assert.svh
// Assertion macros shared by the checker of the mouse event frame latcher.
`ifndef MOUSE_EVENT_FRAME_LATCHER_CORE_ASSERT_SVH
`define MOUSE_EVENT_FRAME_LATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MEFL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MEFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mefl_pkg.sv
`timescale 1ns / 1ps

package mefl_pkg;

   // Action codes of an input beat.
   localparam logic [2:0] ACT_MOVE    = 3'd0;
   localparam logic [2:0] ACT_SET_POS = 3'd1;
   localparam logic [2:0] ACT_WHEEL   = 3'd2;
   localparam logic [2:0] ACT_PRESS   = 3'd3;
   localparam logic [2:0] ACT_RELEASE = 3'd4;
   localparam logic [2:0] ACT_FRAME   = 3'd5;

   // Per-button state codes.
   localparam logic [1:0] BTN_INACTIVE = 2'd0;
   localparam logic [1:0] BTN_DOWN     = 2'd1;
   localparam logic [1:0] BTN_PRESSED  = 2'd2;
   localparam logic [1:0] BTN_RELEASED = 2'd3;

   // Number of button slots in the packed state word.
   localparam int BTN_SLOTS = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN_RD,
      ST_DRAIN_APPLY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic drain_apply;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_frame;
      logic queue_empty;
      logic out_free;
   } sts_type;

   // Signed 16-bit add that clamps to the 16-bit range.
   function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
      logic signed [16:0] s;
      s = {a[15], a} + {b[15], b};
      if (s[16] != s[15]) begin
         return s[16] ? 16'sh8000 : 16'sh7fff;
      end
      return s[15:0];
   endfunction

endpackage

FILE: hw/rtl/mefl_ctrl.sv
`timescale 1ns / 1ps

module mefl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mefl_pkg::sts_type sts,
   output mefl_pkg::cmd_type cmd
);

   mefl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mefl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_stall = 1'b1;
      case (state_ff)
         mefl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = mefl_pkg::ST_EXEC;
            end
         end
         mefl_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_frame ? mefl_pkg::ST_DRAIN_RD : mefl_pkg::ST_DONE;
         end
         mefl_pkg::ST_DRAIN_RD: begin
            // The queue read data register fills during this cycle.
            state_in = sts.queue_empty ? mefl_pkg::ST_DONE : mefl_pkg::ST_DRAIN_APPLY;
         end
         mefl_pkg::ST_DRAIN_APPLY: begin
            cmd.drain_apply = 1'b1;
            state_in        = mefl_pkg::ST_DRAIN_RD;
         end
         mefl_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = mefl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mefl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/mefl_datapath.sv
`timescale 1ns / 1ps

module mefl_datapath #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int BUTTON_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  mefl_pkg::cmd_type   cmd,
   output mefl_pkg::sts_type   sts,
   input  logic [2:0]          req_action,
   input  logic signed [15:0]  req_coord_x,
   input  logic signed [15:0]  req_coord_y,
   input  logic signed [7:0]   req_wheel_step,
   input  logic [2:0]          req_button_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_pos_x,
   output logic signed [15:0]  rsp_pos_y,
   output logic signed [15:0]  rsp_frame_dx,
   output logic signed [15:0]  rsp_frame_dy,
   output logic signed [15:0]  rsp_wheel_total,
   output logic signed [15:0]  rsp_wheel_delta,
   output logic [15:0]         rsp_button_states,
   output logic [4:0]          rsp_queue_count,
   output logic                rsp_dropped
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QC_W  = (CNT_W > 5) ? CNT_W : 5;

   // Captured input beat.
   logic [2:0]         action_ff;
   logic signed [15:0] cx_ff, cy_ff;
   logic signed [7:0]  ws_ff;
   logic [2:0]         btn_ff;

   // Accumulators.
   logic signed [15:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0] whl_ff, whl_in, whl_d_ff, whl_d_in;
   logic               dropped_ff, dropped_in;

   logic [1:0] btn_state_ff [mefl_pkg::BTN_SLOTS];
   logic [1:0] btn_state_in [mefl_pkg::BTN_SLOTS];

   // Event queue: press flag in bit 3, button in bits 2..0.
   logic [3:0]       queue_mem [QUEUE_DEPTH];
   logic [3:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_slot_ff, rd_slot_in, wr_slot_ff, wr_slot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             mem_we;
   logic [3:0]       mem_wdata;

   logic             btn_ok;
   logic [QC_W-1:0]  count_ext;

   // Output register.
   logic               rsp_valid_ff;
   logic signed [15:0] o_pos_x_ff, o_pos_y_ff, o_dx_ff, o_dy_ff, o_whl_ff, o_whl_d_ff;
   logic [15:0]        o_states_ff, states_now;
   logic [4:0]         o_count_ff;
   logic               o_dropped_ff;

   assign btn_ok = {1'b0, btn_ff} < 4'(BUTTON_COUNT);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         cx_ff     <= req_coord_x;
         cy_ff     <= req_coord_y;
         ws_ff     <= req_wheel_step;
         btn_ff    <= req_button_index;
      end
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      whl_in     = whl_ff;
      whl_d_in   = whl_d_ff;
      dropped_in = dropped_ff;
      rd_slot_in = rd_slot_ff;
      wr_slot_in = wr_slot_ff;
      count_in   = count_ff;
      mem_we     = 1'b0;
      mem_wdata  = {(action_ff == mefl_pkg::ACT_PRESS), btn_ff};
      for (int i = 0; i < mefl_pkg::BTN_SLOTS; i++) begin
         btn_state_in[i] = btn_state_ff[i];
      end

      if (cmd.exec) begin
         dropped_in = 1'b0;
         case (action_ff)
            mefl_pkg::ACT_MOVE: begin
               dx_in    = mefl_pkg::sat_add16(dx_ff, cx_ff);
               dy_in    = mefl_pkg::sat_add16(dy_ff, cy_ff);
               pos_x_in = mefl_pkg::sat_add16(pos_x_ff, cx_ff);
               pos_y_in = mefl_pkg::sat_add16(pos_y_ff, cy_ff);
            end
            mefl_pkg::ACT_SET_POS: begin
               dx_in    = '0;
               dy_in    = '0;
               pos_x_in = cx_ff;
               pos_y_in = cy_ff;
            end
            mefl_pkg::ACT_WHEEL: begin
               whl_in   = mefl_pkg::sat_add16(whl_ff, 16'(ws_ff));
               whl_d_in = mefl_pkg::sat_add16(whl_d_ff, 16'(ws_ff));
            end
            mefl_pkg::ACT_PRESS, mefl_pkg::ACT_RELEASE: begin
               if (btn_ok) begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     dropped_in = 1'b1;
                  end else begin
                     mem_we     = 1'b1;
                     wr_slot_in = (wr_slot_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_slot_ff + 1'b1;
                     count_in   = count_ff + 1'b1;
                  end
               end
            end
            mefl_pkg::ACT_FRAME: begin
               dx_in    = '0;
               dy_in    = '0;
               whl_d_in = '0;
               for (int i = 0; i < mefl_pkg::BTN_SLOTS; i++) begin
                  if (i < BUTTON_COUNT) begin
                     if (btn_state_ff[i] == mefl_pkg::BTN_DOWN) begin
                        btn_state_in[i] = mefl_pkg::BTN_PRESSED;
                     end else if (btn_state_ff[i] == mefl_pkg::BTN_RELEASED) begin
                        btn_state_in[i] = mefl_pkg::BTN_INACTIVE;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.drain_apply) begin
         if ({1'b0, rd_data_ff[2:0]} < 4'(BUTTON_COUNT)) begin
            btn_state_in[rd_data_ff[2:0]] = rd_data_ff[3] ? mefl_pkg::BTN_DOWN
                                                          : mefl_pkg::BTN_RELEASED;
         end
         rd_slot_in = (rd_slot_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_ff + 1'b1;
         count_in   = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dx_ff      <= '0;
         dy_ff      <= '0;
         whl_ff     <= '0;
         whl_d_ff   <= '0;
         dropped_ff <= 1'b0;
         rd_slot_ff <= '0;
         wr_slot_ff <= '0;
         count_ff   <= '0;
         for (int i = 0; i < mefl_pkg::BTN_SLOTS; i++) begin
            btn_state_ff[i] <= mefl_pkg::BTN_INACTIVE;
         end
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         whl_ff     <= whl_in;
         whl_d_ff   <= whl_d_in;
         dropped_ff <= dropped_in;
         rd_slot_ff <= rd_slot_in;
         wr_slot_ff <= wr_slot_in;
         count_ff   <= count_in;
         for (int i = 0; i < mefl_pkg::BTN_SLOTS; i++) begin
            btn_state_ff[i] <= btn_state_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[wr_slot_ff] <= mem_wdata;
      end
      rd_data_ff <= queue_mem[rd_slot_ff];
   end

   always_comb begin
      for (int i = 0; i < mefl_pkg::BTN_SLOTS; i++) begin
         states_now[2*i +: 2] = btn_state_ff[i];
      end
   end

   assign count_ext = QC_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_pos_x_ff   <= pos_x_ff;
         o_pos_y_ff   <= pos_y_ff;
         o_dx_ff      <= dx_ff;
         o_dy_ff      <= dy_ff;
         o_whl_ff     <= whl_ff;
         o_whl_d_ff   <= whl_d_ff;
         o_states_ff  <= states_now;
         o_count_ff   <= count_ext[4:0];
         o_dropped_ff <= dropped_ff;
      end
   end

   assign sts.is_frame    = (action_ff == mefl_pkg::ACT_FRAME);
   assign sts.queue_empty = (count_ff == '0);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = o_pos_x_ff;
   assign rsp_pos_y         = o_pos_y_ff;
   assign rsp_frame_dx      = o_dx_ff;
   assign rsp_frame_dy      = o_dy_ff;
   assign rsp_wheel_total   = o_whl_ff;
   assign rsp_wheel_delta   = o_whl_d_ff;
   assign rsp_button_states = o_states_ff;
   assign rsp_queue_count   = o_count_ff;
   assign rsp_dropped       = o_dropped_ff;

endmodule

FILE: hw/rtl/mouse_event_frame_latcher_core.sv
// Each beat is captured and executed, and its snapshot is loaded into the result register
// once that register is free; on a frame update the queued button events are drained before
// the load, one entry at a time by a registered RAM read and then an apply step. The
// controller's accept/execute/deliver sequence takes a new beat only after the last is loaded.
// Reset (synchronous, active high) zeroes position, deltas and wheel, sets every button
// inactive, empties the queue and clears the result valid flag; the queue RAM and result data are not cleared.
`timescale 1ns / 1ps

module mouse_event_frame_latcher_core #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int BUTTON_COUNT = 8
) (
   input  logic               clock,
   input  logic               reset,
   // Input channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [7:0]  req_wheel_step,
   input  logic [2:0]         req_button_index,
   // Result channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_frame_dx,
   output logic signed [15:0] rsp_frame_dy,
   output logic signed [15:0] rsp_wheel_total,
   output logic signed [15:0] rsp_wheel_delta,
   output logic [15:0]        rsp_button_states,
   output logic [4:0]         rsp_queue_count,
   output logic               rsp_dropped
);

   // The controller sequences each beat: it captures the beat, runs the execute
   // step, walks the button event queue on a frame update, and then hands the
   // snapshot to the result register once that register is free. The result
   // register lets the next beat be accepted while a result still waits.
   mefl_pkg::cmd_type cmd;
   mefl_pkg::sts_type sts;

   mefl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the saturating accumulators, the button states, the
   // event queue RAM with its slot pointers and fill count, and the result register.
   mefl_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_wheel_step    (req_wheel_step),
      .req_button_index  (req_button_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_frame_dx      (rsp_frame_dx),
      .rsp_frame_dy      (rsp_frame_dy),
      .rsp_wheel_total   (rsp_wheel_total),
      .rsp_wheel_delta   (rsp_wheel_delta),
      .rsp_button_states (rsp_button_states),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_dropped       (rsp_dropped)
   );

endmodule

FILE: hw/rtl/mefl_checker.sv
`timescale 1ns / 1ps
`include "mouse_event_frame_latcher_core_assert.svh"

module mefl_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_pos_x,
   input logic [4:0]         rsp_queue_count,
   input logic               rsp_dropped
);

   localparam logic [4:0] FULL_COUNT = 5'(QUEUE_DEPTH);

   // A dropped event only happens with a full queue.
   `MEFL_ASSERT_NOW(a_drop_full, clock, reset, rsp_valid && rsp_dropped, rsp_queue_count == FULL_COUNT, "dropped event reported while queue not full")

   // An accepted beat keeps the block busy in the following cycle.
   `MEFL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "beat accepted on back-to-back cycles")

   // A result never follows directly on the accept of the beat that caused it.
   `MEFL_ASSERT_NEXT(a_no_early_rsp, clock, reset, !rsp_valid && req_valid && !req_stall, !rsp_valid, "result appeared right after accept")

   // A stalled result holds.
   `MEFL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pos_x), "stalled result changed")

endmodule

bind mouse_event_frame_latcher_core mefl_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_queue_count (rsp_queue_count),
   .rsp_dropped     (rsp_dropped)
);
